>>> rtl/core/sevs_pkg.sv
package sevs_pkg;

	localparam int DIGITS = 3;
	localparam int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	localparam logic [7:0] SEG_A  = 8'h01;
	localparam logic [7:0] SEG_B  = 8'h02;
	localparam logic [7:0] SEG_C  = 8'h04;
	localparam logic [7:0] SEG_D  = 8'h08;
	localparam logic [7:0] SEG_E  = 8'h10;
	localparam logic [7:0] SEG_F  = 8'h20;
	localparam logic [7:0] SEG_G  = 8'h40;
	localparam logic [7:0] SEG_DP = 8'h80;
	localparam logic [6:0] PATTERN_EIGHT = 7'h7F;
	localparam logic [1:0] SELECT_NONE = 2'd3;

	typedef enum logic [1:0] {
		OP_REFRESH  = 2'd0,
		OP_WRITE    = 2'd1,
		OP_SET_DOT  = 2'd2,
		OP_TEST     = 2'd3
	} sevs_op_t;

	typedef struct packed {
		sevs_op_t    opcode;
		logic [1:0]  position;
		logic [7:0]  char_code;
		logic        flag;
	} sevs_item_t;

	typedef struct packed {
		logic [7:0]  segments;
		logic [1:0]  digit_select;
	} sevs_result_t;

	// handshake into the update logic from the input stage and the output register
	typedef struct packed {
		logic        item_valid;
		logic        out_free;
	} sevs_ctl_t;

	// ASCII to segments a..g; unknown codes show an underscore
	function automatic logic [6:0] decode_char(input logic [7:0] c);
		logic [7:0] s;
		case (c)
			8'h2D: s = SEG_G;                                         // '-'
			8'h20: s = 8'h00;                                         // ' '
			8'h30: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
			8'h31: s = SEG_B | SEG_C;
			8'h32: s = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
			8'h33: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
			8'h34: s = SEG_B | SEG_C | SEG_F | SEG_G;
			8'h35: s = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
			8'h36: s = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			8'h37: s = SEG_A | SEG_B | SEG_C;
			8'h38: s = {1'b0, PATTERN_EIGHT};
			8'h39: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
			8'h41: s = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;  // 'A'
			8'h42: s = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
			8'h43: s = SEG_A | SEG_D | SEG_E | SEG_F;
			8'h44: s = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
			8'h45: s = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
			8'h46: s = SEG_A | SEG_E | SEG_F | SEG_G;
			8'h48: s = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;          // 'H'
			8'h4C: s = SEG_D | SEG_E | SEG_F;                          // 'L'
			8'h4E: s = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F;          // 'N'
			8'h4F: s = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;  // 'O'
			8'h50: s = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G;          // 'P'
			8'h52: s = SEG_A | SEG_E | SEG_F;                          // 'R'
			8'h54: s = SEG_D | SEG_E | SEG_F | SEG_G;                  // 'T'
			default: s = SEG_D;
		endcase
		return s[6:0];
	endfunction

endpackage

>>> rtl/core/sevs_in_stage.sv
module sevs_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sevs_pkg::sevs_item_t in_item,
	input  logic                fire,
	output logic                valid_s1,
	output sevs_pkg::sevs_item_t item_s1
);

	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> rtl/core/sevs_update.sv
module sevs_update (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  display_off,
	input  sevs_pkg::sevs_ctl_t   ctl,
	input  sevs_pkg::sevs_item_t  item_s1,
	output logic                  fire,
	output logic                  emit,
	output sevs_pkg::sevs_result_t result
);

	localparam int DW = sevs_pkg::DIGIT_W;

	// characters and dots kept apart so set dot needs no read of the buffer
	logic [6:0]    char_q [sevs_pkg::DIGITS];
	logic          dot_q  [sevs_pkg::DIGITS];
	logic [DW-1:0] active_q;
	logic          test_lock_q;
	logic [7:0]    held_q;

	logic          is_refresh;
	logic          pos_ok;
	logic [DW-1:0] widx;
	logic [DW-1:0] ad;
	logic [DW-1:0] ad_next;
	logic [7:0]    cur_seg;
	logic [6:0]    new_char;

	always_comb begin
		is_refresh = (item_s1.opcode == sevs_pkg::OP_REFRESH);
		fire = ctl.item_valid && (!is_refresh || ctl.out_free);
		emit = fire && is_refresh;
		pos_ok = (32'(item_s1.position) < sevs_pkg::DIGITS);
		widx = DW'(item_s1.position);
		ad = (32'(active_q) >= sevs_pkg::DIGITS) ? '0 : active_q;
		ad_next = (32'(ad) >= sevs_pkg::DIGITS - 1) ? '0 : DW'(32'(ad) + 1);
		cur_seg = {dot_q[ad], char_q[ad]};
		new_char = sevs_pkg::decode_char(item_s1.char_code);
		if (display_off) begin
			result.segments = held_q;
			result.digit_select = sevs_pkg::SELECT_NONE;
		end else begin
			result.segments = cur_seg;
			result.digit_select = 2'(ad);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sevs_pkg::DIGITS; i++) begin
				char_q[i] <= sevs_pkg::PATTERN_EIGHT;
				dot_q[i] <= 1'b0;
			end
			active_q <= '0;
			test_lock_q <= 1'b1;
			held_q <= '0;
		end else if (fire) begin
			case (item_s1.opcode)
				sevs_pkg::OP_REFRESH: begin
					if (!display_off) begin
						held_q <= cur_seg;
						active_q <= ad_next;
					end
				end
				sevs_pkg::OP_WRITE: begin
					if (pos_ok && !test_lock_q) begin
						for (int i = 0; i < sevs_pkg::DIGITS; i++) begin
							if (DW'(i) == widx) begin
								char_q[i] <= new_char;
								dot_q[i] <= item_s1.flag;
							end
						end
					end
				end
				sevs_pkg::OP_SET_DOT: begin
					if (pos_ok) begin
						for (int i = 0; i < sevs_pkg::DIGITS; i++) begin
							if (DW'(i) == widx) begin
								dot_q[i] <= item_s1.flag;
							end
						end
					end
				end
				sevs_pkg::OP_TEST: begin
					if (!test_lock_q && item_s1.flag) begin
						for (int i = 0; i < sevs_pkg::DIGITS; i++) begin
							char_q[i] <= sevs_pkg::PATTERN_EIGHT;
							dot_q[i] <= 1'b0;
						end
					end
					test_lock_q <= item_s1.flag;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/core/sevs_out_reg.sv
module sevs_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   emit,
	input  sevs_pkg::sevs_result_t result,
	output logic                   out_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sevs_pkg::sevs_result_t out_data
);

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			out_data <= result;
		end
	end

endmodule

>>> rtl/core/seven_segment_mux_driver_unit.sv
// channel   dir  payload                                  beat when
// s_axis    in   tuser opcode, tdata position/char/flag   s_axis_tvalid && s_axis_tready
// m_axis    out  tdata segments, digit_select             m_axis_tvalid && m_axis_tready
// cfg       in   cfg_data = display_off                   cfg_valid && cfg_ready
//
// One item per cycle sustained while no refresh tick is held back. An input beat is
// registered; from there the buffer update and the refresh result are registered.
// Only a refresh tick needs the result register: it waits in the input register, and
// holds back the beats behind it, while an unaccepted result sits on m_axis.
// Reset shows 888 without dots, digit 0 active, test mode on, display on.
// cfg_ready is always high.
module seven_segment_mux_driver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [1:0] position, [9:2] char_code, [10] flag, zero pad
	input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] segments, [9:8] digit_select, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	sevs_pkg::sevs_item_t   in_item;
	sevs_pkg::sevs_item_t   item_s1;
	sevs_pkg::sevs_result_t result;
	sevs_pkg::sevs_result_t out_data;
	sevs_pkg::sevs_ctl_t    ctl;
	logic                   valid_s1;
	logic                   fire;
	logic                   emit;
	logic                   out_free;
	logic                   display_off_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_off_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			display_off_q <= cfg_data;
		end
	end

	always_comb begin
		in_item.opcode = sevs_pkg::sevs_op_t'(s_axis_tuser);
		in_item.position = s_axis_tdata[1:0];
		in_item.char_code = s_axis_tdata[9:2];
		in_item.flag = s_axis_tdata[10];
		ctl.item_valid = valid_s1;
		ctl.out_free = out_free;
		m_axis_tdata = {6'b0, out_data.digit_select, out_data.segments};
	end

	sevs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sevs_update u_upd (
		.clk         (clk),
		.arst_n      (arst_n),
		.display_off (display_off_q),
		.ctl         (ctl),
		.item_s1     (item_s1),
		.fire        (fire),
		.emit        (emit),
		.result      (result)
	);

	sevs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.result    (result),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

endmodule

>>> rtl/core/sevs_checker.sv
module sevs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_ready
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// with no result pending the input side never stalls
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:10] == 6'b0)
		else $error("result padding not zero");

	// reset may only be seen at an edge, so the result is clear by the next one
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid && cfg_ready)
		else $error("result valid during reset");

endmodule

bind seven_segment_mux_driver_unit sevs_checker u_sevs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);
